// ===== src/e2q_pkg.sv =====
// ---------------------------------------------------------------------------
// e2q_pkg: shared types and constants for the Euler-to-quaternion block.
// Holds the CORDIC angle table, fixed-point constants and payload types.
// ---------------------------------------------------------------------------
package e2q_pkg;

   localparam int CordicSteps = 16;
   localparam int AngleWidth = 16;
   localparam int CompWidth = 16;
   localparam int ZWidth = 20;
   localparam int XyWidth = 33;
   localparam int TrigWidth = 17;

   localparam logic signed [XyWidth-1:0] CordicGain = 33'sd652032874;
   localparam logic signed [ZWidth-1:0] HalfPi = 20'sd102944;
   localparam logic signed [ZWidth-1:0] Pi = 20'sd205887;
   localparam logic signed [TrigWidth-1:0] OneQ15 = 17'sd32768;

   typedef struct packed {
      logic signed [AngleWidth-1:0] roll_angle;
      logic signed [AngleWidth-1:0] pitch_angle;
      logic signed [AngleWidth-1:0] yaw_angle;
   } req_type;

   typedef struct packed {
      logic signed [CompWidth-1:0] quat_w;
      logic signed [CompWidth-1:0] quat_x;
      logic signed [CompWidth-1:0] quat_y;
      logic signed [CompWidth-1:0] quat_z;
   } rsp_type;

   // State of one CORDIC lane between stages.
   typedef struct packed {
      logic signed [XyWidth-1:0] x;
      logic signed [XyWidth-1:0] y;
      logic signed [ZWidth-1:0] z;
      logic neg;
   } cordic_type;

   // Arctangent of 2^-i in Q16 radians.
   function automatic logic signed [ZWidth-1:0] atan_q16(input logic [3:0] idx);
      logic signed [ZWidth-1:0] res;
      unique case (idx)
         4'd0: res = 20'sd51472;
         4'd1: res = 20'sd30386;
         4'd2: res = 20'sd16055;
         4'd3: res = 20'sd8150;
         4'd4: res = 20'sd4091;
         4'd5: res = 20'sd2047;
         4'd6: res = 20'sd1024;
         4'd7: res = 20'sd512;
         4'd8: res = 20'sd256;
         4'd9: res = 20'sd128;
         4'd10: res = 20'sd64;
         4'd11: res = 20'sd32;
         4'd12: res = 20'sd16;
         4'd13: res = 20'sd8;
         4'd14: res = 20'sd4;
         default: res = 20'sd2;
      endcase
      return res;
   endfunction

endpackage

// ===== src/e2q_stream_if.sv =====
// ---------------------------------------------------------------------------
// e2q_stream_if: valid/ready channel carrying one payload.
// A transfer happens on a rising clock edge with valid and ready high.
// ---------------------------------------------------------------------------
interface e2q_stream_if #(
   parameter type payload_type = logic
);
   logic valid;
   logic ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== src/e2q_cordic.sv =====
// ---------------------------------------------------------------------------
// e2q_cordic: pipelined half-angle cosine/sine unit.
// Range reduction, sixteen registered CORDIC steps and a rounding stage.
// ---------------------------------------------------------------------------
module e2q_cordic (
   input  logic clock,
   input  logic advance,
   input  logic signed [e2q_pkg::AngleWidth-1:0] angle,
   output logic signed [e2q_pkg::TrigWidth-1:0] cos_val,
   output logic signed [e2q_pkg::TrigWidth-1:0] sin_val
);
   import e2q_pkg::*;

   cordic_type stage_ff [CordicSteps+1];
   cordic_type stage_in [CordicSteps+1];
   logic signed [TrigWidth-1:0] cos_ff, sin_ff, cos_in, sin_in;

   // Halve the angle into Q16 and fold it into [-pi/2, pi/2].
   always_comb begin
      logic signed [ZWidth-1:0] z0;
      z0 = ZWidth'(angle) <<< 2;
      stage_in[0].x = CordicGain;
      stage_in[0].y = '0;
      stage_in[0].neg = 1'b0;
      stage_in[0].z = z0;
      if (z0 > HalfPi) begin
         stage_in[0].z = z0 - Pi;
         stage_in[0].neg = 1'b1;
      end else if (z0 < -HalfPi) begin
         stage_in[0].z = z0 + Pi;
         stage_in[0].neg = 1'b1;
      end
   end

   // One micro-rotation per stage.
   for (genvar i = 0; i < CordicSteps; i++) begin : g_step
      always_comb begin
         logic signed [XyWidth-1:0] dx, dy;
         dx = stage_ff[i].y >>> i;
         dy = stage_ff[i].x >>> i;
         stage_in[i+1].neg = stage_ff[i].neg;
         if (!stage_ff[i].z[ZWidth-1]) begin
            stage_in[i+1].x = stage_ff[i].x - dx;
            stage_in[i+1].y = stage_ff[i].y + dy;
            stage_in[i+1].z = stage_ff[i].z - atan_q16(4'(i));
         end else begin
            stage_in[i+1].x = stage_ff[i].x + dx;
            stage_in[i+1].y = stage_ff[i].y - dy;
            stage_in[i+1].z = stage_ff[i].z + atan_q16(4'(i));
         end
      end
   end

   // Negate for folded angles, round to Q15 and clamp to +-1.0.
   always_comb begin
      logic signed [XyWidth:0] xs, ys, xr, yr;
      xs = stage_ff[CordicSteps].neg ? -(XyWidth+1)'(stage_ff[CordicSteps].x)
                                     : (XyWidth+1)'(stage_ff[CordicSteps].x);
      ys = stage_ff[CordicSteps].neg ? -(XyWidth+1)'(stage_ff[CordicSteps].y)
                                     : (XyWidth+1)'(stage_ff[CordicSteps].y);
      xr = (xs + (XyWidth+1)'(1 << 14)) >>> 15;
      yr = (ys + (XyWidth+1)'(1 << 14)) >>> 15;
      if (xr > (XyWidth+1)'(OneQ15)) cos_in = OneQ15;
      else if (xr < -(XyWidth+1)'(OneQ15)) cos_in = -OneQ15;
      else cos_in = TrigWidth'(xr);
      if (yr > (XyWidth+1)'(OneQ15)) sin_in = OneQ15;
      else if (yr < -(XyWidth+1)'(OneQ15)) sin_in = -OneQ15;
      else sin_in = TrigWidth'(yr);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k <= CordicSteps; k++) stage_ff[k] <= stage_in[k];
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign cos_val = cos_ff;
   assign sin_val = sin_ff;
endmodule

// ===== src/euler_to_quaternion.sv =====
// Accepts one item per cycle while the output is not stalled.
// Throughput is set by the fully pipelined CORDIC lanes and product stages.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// Reset (synchronous, active high) clears all valid bits; no data is kept.
// ---------------------------------------------------------------------------
// euler_to_quaternion: Z-Y-X Euler angles to unit quaternion.
// Three CORDIC lanes, two product stages and a sum/round stage into the output reg.
// ---------------------------------------------------------------------------
module euler_to_quaternion (
   input logic clock,
   input logic reset,
   e2q_stream_if.sink   req,
   e2q_stream_if.source rsp
);
   import e2q_pkg::*;

   localparam int Depth = CordicSteps + 5;
   localparam int PairWidth = 2 * TrigWidth;
   localparam int ProdWidth = 3 * TrigWidth;

   logic advance;
   logic [Depth-1:0] valid_ff, valid_in;
   logic signed [TrigWidth-1:0] cr, sr, cp, sp, cy, sy;
   logic signed [TrigWidth-1:0] cy_ff, sy_ff;
   logic signed [PairWidth-1:0] p_cc_ff, p_cs_ff, p_sc_ff, p_ss_ff;
   logic signed [ProdWidth-1:0] t_ff [8];
   logic signed [ProdWidth:0] s_w, s_x, s_y, s_z;
   rsp_type out_ff, out_in;

   // Pipeline moves whenever the output slot is free or being taken.
   assign advance = !valid_ff[Depth-1] || rsp.ready;
   assign req.ready = advance;

   e2q_cordic u_roll  (.clock, .advance, .angle(req.data.roll_angle),
                       .cos_val(cr), .sin_val(sr));
   e2q_cordic u_pitch (.clock, .advance, .angle(req.data.pitch_angle),
                       .cos_val(cp), .sin_val(sp));
   e2q_cordic u_yaw   (.clock, .advance, .angle(req.data.yaw_angle),
                       .cos_val(cy), .sin_val(sy));

   assign valid_in = {valid_ff[Depth-2:0], req.valid};

   // Rounds a Q45 sum to Q15 with saturation.
   function automatic logic signed [CompWidth-1:0] to_q15(
      input logic signed [ProdWidth:0] v);
      logic signed [ProdWidth:0] r;
      r = (v + (ProdWidth+1)'(1 << 29)) >>> 30;
      if (r > (ProdWidth+1)'(32767)) return 16'sh7fff;
      if (r < -(ProdWidth+1)'(32768)) return 16'sh8000;
      return CompWidth'(r);
   endfunction

   assign s_w = (ProdWidth+1)'(t_ff[0]) + (ProdWidth+1)'(t_ff[1]);
   assign s_x = (ProdWidth+1)'(t_ff[2]) - (ProdWidth+1)'(t_ff[3]);
   assign s_y = (ProdWidth+1)'(t_ff[4]) + (ProdWidth+1)'(t_ff[5]);
   assign s_z = (ProdWidth+1)'(t_ff[6]) - (ProdWidth+1)'(t_ff[7]);

   always_comb begin
      out_in.quat_w = to_q15(s_w);
      out_in.quat_x = to_q15(s_x);
      out_in.quat_y = to_q15(s_y);
      out_in.quat_z = to_q15(s_z);
   end

   // Roll-pitch pair products, then the yaw factor, then sums.
   always_ff @(posedge clock) begin
      if (advance) begin
         p_cc_ff <= cr * cp;
         p_cs_ff <= cr * sp;
         p_sc_ff <= sr * cp;
         p_ss_ff <= sr * sp;
         cy_ff <= cy;
         sy_ff <= sy;
         t_ff[0] <= p_cc_ff * cy_ff;
         t_ff[1] <= p_ss_ff * sy_ff;
         t_ff[2] <= p_sc_ff * cy_ff;
         t_ff[3] <= p_cs_ff * sy_ff;
         t_ff[4] <= p_cs_ff * cy_ff;
         t_ff[5] <= p_sc_ff * sy_ff;
         t_ff[6] <= p_cc_ff * sy_ff;
         t_ff[7] <= p_ss_ff * cy_ff;
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   assign rsp.valid = valid_ff[Depth-1];
   assign rsp.data = out_ff;
endmodule

// ===== src/e2q_checker.sv =====
// ---------------------------------------------------------------------------
// e2q_checker: port-level checks for euler_to_quaternion.
// Watches the handshake and the quat_w result; bound to the top level.
// ---------------------------------------------------------------------------
module e2q_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic signed [15:0] rsp_w
);
   // Output stays offered until taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // Input is refused only while the output is stalled.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input refused without output stall");

   // No result appears in the cycle after reset.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result after reset");

   // A stalled result keeps its value until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_w))
      else $error("result changed while stalled");
endmodule

bind euler_to_quaternion e2q_checker u_e2q_checker (
   .clock(clock),
   .reset(reset),
   .req_ready(req.ready),
   .rsp_valid(rsp.valid),
   .rsp_ready(rsp.ready),
   .rsp_w(rsp.data.quat_w)
);

// ===== tb/tb_euler_to_quaternion.sv =====
// ---------------------------------------------------------------------------
// tb_euler_to_quaternion: self-checking testbench for the angle converter.
// Drives roll/pitch/yaw triples, predicts each quaternion with a CORDIC
// model of its own, and compares every result transfer field by field.
// ---------------------------------------------------------------------------
module tb_euler_to_quaternion;
   import e2q_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   e2q_stream_if #(.payload_type(req_type)) req ();
   e2q_stream_if #(.payload_type(rsp_type)) rsp ();

   euler_to_quaternion dut (
      .clock(clock),
      .reset(reset),
      .req(req),
      .rsp(rsp)
   );

   always #5 clock = ~clock;

   rsp_type quat_queue[$];
   int      errors = 0;
   int      sent_count = 0;
   int      checked_count = 0;
   int      send_idle_pct = 0;
   int      recv_stall_pct = 0;
   int      hold_cycles = 0;

   // Half-angle cosine and sine in Q15 by a 16-step CORDIC.
   function automatic void half_trig(input logic signed [15:0] ang,
                                     output longint c, output longint s);
      longint atan_tab[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                               256, 128, 64, 32, 16, 8, 4, 2};
      longint z, x, y, dx, dy;
      bit     flip;
      z = longint'(ang) * 4;
      x = 652032874;
      y = 0;
      flip = 1'b0;
      if (z > 102944) begin
         z -= 205887;
         flip = 1'b1;
      end else if (z < -102944) begin
         z += 205887;
         flip = 1'b1;
      end
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_tab[i];
         end else begin
            x += dx; y -= dy; z += atan_tab[i];
         end
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      c = (x + (64'sd1 <<< 14)) >>> 15;
      s = (y + (64'sd1 <<< 14)) >>> 15;
      if (c > 32768) c = 32768;
      if (c < -32768) c = -32768;
      if (s > 32768) s = 32768;
      if (s < -32768) s = -32768;
   endfunction

   // Rounds a Q45 sum to Q15 with saturation.
   function automatic logic signed [15:0] round_q15(input longint v);
      longint r;
      r = (v + (64'sd1 <<< 29)) >>> 30;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
   endfunction

   function automatic rsp_type predict_quat(input req_type a);
      longint cr, sr, cp, sp, cy, sy;
      rsp_type q;
      half_trig(a.roll_angle, cr, sr);
      half_trig(a.pitch_angle, cp, sp);
      half_trig(a.yaw_angle, cy, sy);
      q.quat_w = round_q15(cr * cp * cy + sr * sp * sy);
      q.quat_x = round_q15(sr * cp * cy - cr * sp * sy);
      q.quat_y = round_q15(cr * sp * cy + sr * cp * sy);
      q.quat_z = round_q15(cr * cp * sy - sr * sp * cy);
      return q;
   endfunction

   // Sends one angle triple, with random idle cycles before it.
   task automatic send_angles(input logic [15:0] r, input logic [15:0] p,
                              input logic [15:0] y);
      req_type a;
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      a.roll_angle = r;
      a.pitch_angle = p;
      a.yaw_angle = y;
      req.data <= a;
      req.valid <= 1'b1;
      do @(posedge clock); while (!req.ready);
      quat_queue.push_back(predict_quat(a));
      sent_count++;
      @(negedge clock);
   endtask

   task automatic idle_sender();
      req.valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      idle_sender();
      while (quat_queue.size() != 0) @(negedge clock);
   endtask

   // Receiver ready: random stalls, or a long counted hold-off.
   always @(negedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         rsp.ready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Compares each result transfer with the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (quat_queue.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp.data);
            errors++;
         end else begin
            want = quat_queue.pop_front();
            checked_count++;
            if (want.quat_w !== rsp.data.quat_w) begin
               $display("%0t: quat_w expected %0d actual %0d", $time,
                        want.quat_w, rsp.data.quat_w);
               errors++;
            end
            if (want.quat_x !== rsp.data.quat_x) begin
               $display("%0t: quat_x expected %0d actual %0d", $time,
                        want.quat_x, rsp.data.quat_x);
               errors++;
            end
            if (want.quat_y !== rsp.data.quat_y) begin
               $display("%0t: quat_y expected %0d actual %0d", $time,
                        want.quat_y, rsp.data.quat_y);
               errors++;
            end
            if (want.quat_z !== rsp.data.quat_z) begin
               $display("%0t: quat_z expected %0d actual %0d", $time,
                        want.quat_z, rsp.data.quat_z);
               errors++;
            end
         end
      end
   end

   // Extremes, range-reduction edges, and the out-of-range patterns.
   task automatic test_directed();
      logic [15:0] pts[12] = '{16'h0000, 16'sd25736, -16'sd25736, 16'h7FFF,
                               16'h8000, 16'sd12868, -16'sd12868, 16'sd25737,
                               -16'sd25737, 16'sd6434, 16'h0001, 16'hFFFF};
      foreach (pts[i]) send_angles(pts[i], 16'h0000, 16'h0000);
      send_angles(16'h0000, 16'sd25736, 16'h0000);
      send_angles(16'h0000, 16'h0000, -16'sd25736);
      send_angles(16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_angles(16'h8000, 16'h8000, 16'h8000);
      send_angles(16'sd12868, 16'sd12868, 16'sd12868);
      send_angles(-16'sd12868, 16'sd25736, 16'h8000);
      send_angles(16'hAAAA, 16'h5555, 16'hAAAA);
      send_angles(16'h5555, 16'hAAAA, 16'h5555);
   endtask

   // Random triples, mostly in -pi..pi with some full-range patterns.
   task automatic test_random(input int count);
      logic [15:0] v[3];
      for (int n = 0; n < count; n++) begin
         foreach (v[k])
            v[k] = ($urandom_range(9) == 0) ? 16'($urandom)
                                             : 16'($urandom_range(51472) - 25736);
         send_angles(v[0], v[1], v[2]);
      end
   endtask

   // Long receiver hold-off while the sender keeps offering items.
   task automatic test_backpressure();
      hold_cycles = 80;
      test_random(130);
      wait_drained();
   endtask

   initial begin
      req.valid = 1'b0;
      req.data = '0;
      rsp.ready = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      wait_drained();
      test_random(200);
      send_idle_pct = 45;
      test_random(200);
      send_idle_pct = 0;
      recv_stall_pct = 45;
      test_random(200);
      send_idle_pct = 12;
      recv_stall_pct = 12;
      test_random(200);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      test_backpressure();

      wait_drained();
      repeat (30) @(negedge clock);
      $display("Covered %0d angle triples (edges, wrap, full-range patterns),",
               sent_count);
      $display("%0d quaternions checked under idle, stall and hold-off phases.",
               checked_count);
      if (errors == 0 && quat_queue.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #2000000;
      $display("simulation failed");
      $finish;
   end
endmodule
